### rtl/core/mgrf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrf_pkg
// s-box table, pi layer and byte shuffle for the magenta round function
// ----------------------------------------------------------------------------
package mgrf_pkg;

    localparam int NumBytes  = 16;
    localparam int HalfBytes = 8;
    localparam int NumPi     = 12;
    localparam int PiPerT    = 4;
    localparam logic [8:0] SboxPoly = 9'h165;

    // byte i of a vector sits at index NumBytes-1-i (byte 0 in the top bits)
    typedef logic [NumBytes-1:0][7:0] mg_vec_t;
    typedef logic [7:0] sbox_tab_t [256];

    typedef struct packed {
        mg_vec_t state;
        mg_vec_t x;
    } stage_t;

    function automatic sbox_tab_t build_sbox();
        sbox_tab_t  tab;
        logic [8:0] v;
        v = 9'd1;
        for (int i = 0; i < 255; i++)
        begin
            tab[i] = v[7:0];
            v = {v[7:0], 1'b0};
            if (v[8])
            begin
                v = v ^ SboxPoly;
            end
        end
        tab[255] = 8'd0;
        return tab;
    endfunction

    localparam sbox_tab_t Sbox = build_sbox();

    function automatic logic [7:0] mix_a(input logic [7:0] a, input logic [7:0] b);
        logic [7:0] fb;
        fb = Sbox[b];
        return Sbox[a ^ fb];
    endfunction

    function automatic mg_vec_t pi_layer(input mg_vec_t v);
        mg_vec_t t;
        for (int i = 0; i < HalfBytes; i++)
        begin
            t[NumBytes-1-2*i] = mix_a(v[NumBytes-1-i], v[HalfBytes-1-i]);
            t[NumBytes-2-2*i] = mix_a(v[HalfBytes-1-i], v[NumBytes-1-i]);
        end
        return t;
    endfunction

    // even bytes first, then odd bytes
    function automatic mg_vec_t shuffle(input mg_vec_t v);
        mg_vec_t d;
        for (int i = 0; i < HalfBytes; i++)
        begin
            d[NumBytes-1-i]  = v[NumBytes-1-2*i];
            d[HalfBytes-1-i] = v[NumBytes-2-2*i];
        end
        return d;
    endfunction

endpackage

### rtl/core/mgrf_stage.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mgrf_stage
// one registered pi layer, optionally preceded by the x xor shuffle feedback
// ----------------------------------------------------------------------------
module mgrf_stage
    import mgrf_pkg::*;
#(
    parameter bit MIX = 1'b0
)
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   in_valid,
    output logic   in_ready,
    input  stage_t in_data,
    output logic   out_valid,
    input  logic   out_ready,
    output stage_t out_data
);

    logic    valid_reg;
    stage_t  data_reg;
    stage_t  data_next;
    mg_vec_t pi_in;

    assign in_ready = !valid_reg || out_ready;

    always_comb
    begin
        if (MIX)
        begin
            pi_in = in_data.x ^ shuffle(in_data.state);
        end
        else
        begin
            pi_in = in_data.state;
        end
        data_next.state = pi_layer(pi_in);
        data_next.x     = in_data.x;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

`ifndef SYNTH
    a_take_fills: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> valid_reg)
        else $error("accepted transaction not held in stage");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && !out_ready |=> valid_reg && $stable(data_reg))
        else $error("stalled stage lost or changed its transaction");

    a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg && out_ready && !in_valid |=> !valid_reg)
        else $error("drained stage repeats its transaction");
`endif

endmodule

### rtl/core/magenta_round_function.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// magenta_round_function
// magenta cipher round function as a twelve-stage pipeline
// ----------------------------------------------------------------------------
// Takes one half block and round key per cycle unless stalled and returns
// the 64-bit round output once the pair has passed the last stage. Each
// stage holds one pi layer (two s-box lookups in series per byte); stages
// five and nine first fold the shuffled intermediate back into the original
// input. An output stall holds full stages back to the first empty one.
module magenta_round_function
    import mgrf_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [127:0]  s_axis_tdata,   // blk_half [63:0], round_key [127:64]
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [63:0]   m_axis_tdata    // round_out [63:0]
);

    logic   valid [NumPi+1];
    logic   ready [NumPi+1];
    stage_t data  [NumPi+1];
    mg_vec_t c3;

    assign valid[0]      = s_axis_tvalid;
    assign s_axis_tready = ready[0];
    assign data[0].state = {s_axis_tdata[63:0], s_axis_tdata[127:64]};
    assign data[0].x     = {s_axis_tdata[63:0], s_axis_tdata[127:64]};

    for (genvar g = 0; g < NumPi; g++)
    begin : g_stage
        mgrf_stage #(
            .MIX (g != 0 && (g % PiPerT) == 0)
        ) u_stage (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (valid[g]),
            .in_ready  (ready[g]),
            .in_data   (data[g]),
            .out_valid (valid[g+1]),
            .out_ready (ready[g+1]),
            .out_data  (data[g+1])
        );
    end

    assign ready[NumPi]  = m_axis_tready;
    assign m_axis_tvalid = valid[NumPi];

    // top half of c3: the even bytes of the last stage's state, byte 0 on top
    assign c3 = shuffle(data[NumPi].state);
    assign m_axis_tdata = c3[NumBytes-1:HalfBytes];

endmodule

### sim/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// stream-level check of the magenta round function against a local model
// ----------------------------------------------------------------------------
// Half block and round key pairs go in on the slave stream: first a set of
// corner patterns, then random pairs in bursts with random gaps. Each accepted
// pair is run through a behavioural model of the round function. The expected
// outputs wait in order and are compared with every result on the master
// stream. The receiver stalls on a changing pattern of its own.

class round_out_checker;

    typedef logic [0:15][7:0] mg_bytes_t;

    logic [7:0] alpha_pow [256];
    logic [63:0] pending_round_out [$];
    int errors;

    function new();
        logic [8:0] v;
        v = 9'd1;
        for (int i = 0; i < 255; i++)
        begin
            alpha_pow[i] = v[7:0];
            v = {v[7:0], 1'b0};
            if (v[8])
            begin
                v = v ^ 9'h165;
            end
        end
        alpha_pow[255] = 8'd0;
        errors = 0;
    endfunction

    function logic [7:0] mix_pair(logic [7:0] a, logic [7:0] b);
        return alpha_pow[a ^ alpha_pow[b]];
    endfunction

    // four pi layers
    function mg_bytes_t t_transform(mg_bytes_t v);
        mg_bytes_t w;
        w = v;
        for (int r = 0; r < 4; r++)
        begin
            for (int i = 0; i < 8; i++)
            begin
                v[2*i]     = mix_pair(w[i], w[i+8]);
                v[2*i + 1] = mix_pair(w[i+8], w[i]);
            end
            w = v;
        end
        return w;
    endfunction

    function mg_bytes_t even_odd_split(mg_bytes_t v);
        mg_bytes_t d;
        for (int i = 0; i < 8; i++)
        begin
            d[i]     = v[2*i];
            d[i + 8] = v[2*i + 1];
        end
        return d;
    endfunction

    function logic [63:0] magenta_f(logic [63:0] blk_half, logic [63:0] round_key);
        mg_bytes_t x;
        mg_bytes_t c;
        logic [63:0] r;
        x = {blk_half, round_key};
        c = t_transform(x);
        for (int k = 2; k <= 3; k++)
        begin
            c = t_transform(x ^ even_odd_split(c));
        end
        r = '0;
        for (int i = 0; i < 8; i++)
        begin
            r = {r[55:0], c[2*i]};
        end
        return r;
    endfunction

    function void note_block(logic [63:0] blk_half, logic [63:0] round_key);
        pending_round_out = {pending_round_out, magenta_f(blk_half, round_key)};
    endfunction

    function void check_round_out(logic [63:0] actual);
        logic [63:0] expected;
        if (pending_round_out.size() == 0)
        begin
            $error("round_out with no transaction pending: actual %h", actual);
            errors++;
        end
        else
        begin
            expected = pending_round_out.pop_front();
            if (actual !== expected)
            begin
                $error("round_out mismatch: expected %h, actual %h", expected, actual);
                errors++;
            end
        end
    endfunction

endclass

module testbench;

    localparam int NumRandom  = 900;
    localparam int StallLimit = 1000;
    localparam int TailCycles = 40;

    logic          clk;
    logic          rst_n;
    logic          s_axis_tvalid;
    logic          s_axis_tready;
    logic [127:0]  s_axis_tdata;   // blk_half [63:0], round_key [127:64]
    logic          m_axis_tvalid;
    logic          m_axis_tready;
    logic [63:0]   m_axis_tdata;   // round_out [63:0]

    round_out_checker sb;
    int stall_count = 0;

    magenta_round_function dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // monitor: record accepted transactions on both streams
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                sb.note_block(s_axis_tdata[63:0], s_axis_tdata[127:64]);
            end
            if (m_axis_tvalid && m_axis_tready)
            begin
                sb.check_round_out(m_axis_tdata);
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            begin
                stall_count <= 0;
            end
            else
            begin
                stall_count <= stall_count + 1;
            end
        end
    end

    // watchdog
    initial
    begin
        while (stall_count < StallLimit)
        begin
            @(posedge clk);
        end
        $display("Regression FAIL");
        $finish;
    end

    // receiver back-pressure in segments of differing character
    initial
    begin
        int mode;
        int seg_len;
        int hold;
        m_axis_tready = 1'b0;
        forever
        begin
            mode    = $urandom_range(0, 3);
            seg_len = $urandom_range(20, 120);
            hold    = $urandom_range(1, 15);
            for (int n = 0; n < seg_len; n++)
            begin
                @(negedge clk);
                case (mode)
                    0: m_axis_tready <= 1'b1;
                    1: m_axis_tready <= 1'($urandom_range(0, 1));
                    2: m_axis_tready <= (n % 3 != 0);
                    default: m_axis_tready <= (n >= hold);
                endcase
            end
        end
    end

    task automatic send_pair(input logic [63:0] blk_half, input logic [63:0] round_key);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {round_key, blk_half};
        do
        begin
            @(posedge clk);
        end
        while (!s_axis_tready);
    endtask

    task automatic idle_sender(input int cycles);
        repeat (cycles)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= {$urandom, $urandom, $urandom, $urandom};
        end
    endtask

    function automatic logic [63:0] random_word();
        return {$urandom, $urandom};
    endfunction

    // bytes drawn mostly from the s-box corners (zero, all ones, single bits)
    function automatic logic [63:0] corner_byte_word();
        logic [63:0] w;
        logic [7:0] b;
        w = '0;
        for (int i = 0; i < 8; i++)
        begin
            case ($urandom_range(0, 4))
                0: b = 8'h00;
                1: b = 8'hff;
                2: b = 8'h01;
                3: b = 8'h80;
                default: b = 8'($urandom_range(0, 255));
            endcase
            w = {w[55:0], b};
        end
        return w;
    endfunction

    task automatic send_random_pair();
        logic [63:0] hb;
        logic [63:0] rk;
        case ($urandom_range(0, 9))
            6:
            begin
                hb = corner_byte_word();
                rk = corner_byte_word();
            end
            7:
            begin
                hb = random_word();
                rk = '0;
            end
            8:
            begin
                hb = '1;
                rk = random_word();
            end
            9:
            begin
                hb = 64'd1 << $urandom_range(0, 63);
                rk = 64'd1 << $urandom_range(0, 63);
            end
            default:
            begin
                hb = random_word();
                rk = random_word();
            end
        endcase
        send_pair(hb, rk);
    endtask

    initial
    begin
        int sent;
        int burst;
        sb            = new();
        rst_n         = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        idle_sender(2);

        // corner patterns
        send_pair(64'h0, 64'h0);
        send_pair('1, '1);
        send_pair('1, 64'h0);
        send_pair(64'h0, '1);
        send_pair(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa);
        send_pair(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555);
        send_pair(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210);
        send_pair(64'h8000_0000_0000_0001, 64'h0000_0000_0000_0001);
        send_pair(64'h0101_0101_0101_0101, 64'h8080_8080_8080_8080);
        send_pair(64'hff00_ff00_ff00_ff00, 64'h00ff_00ff_00ff_00ff);
        send_pair(64'h0000_0000_0000_00ff, 64'hff00_0000_0000_0000);
        send_pair(64'hfeff_fffe_fffe_fffe, 64'h0102_0408_1020_4080);
        idle_sender(3);

        sent = 0;
        while (sent < NumRandom)
        begin
            burst = $urandom_range(1, 30);
            for (int i = 0; i < burst && sent < NumRandom; i++)
            begin
                send_random_pair();
                sent++;
            end
            if ($urandom_range(0, 3) != 0)
            begin
                idle_sender($urandom_range(1, 8));
            end
        end
        idle_sender(1);

        while (sb.pending_round_out.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (TailCycles) @(posedge clk);
        if (sb.errors == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
